>>> rtl/core/adc_offset_calibrate_and_scale_core_assert.svh
// Assertion shorthands shared by the calibration core modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ADC_OFFSET_CALIBRATE_AND_SCALE_CORE_ASSERT_SVH
`define ADC_OFFSET_CALIBRATE_AND_SCALE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AOCS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aocs same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AOCS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aocs next-cycle check failed");

`endif

>>> rtl/core/aocs_pkg.sv
package aocs_pkg;

    localparam int DATA_W     = 16;
    localparam int CH_FIELD_W = 3;
    localparam int SUM_W      = 18;
    localparam int ROUND_W    = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DATA_W-1:0]  MID_SCALE       = 16'h8000;
    localparam logic [DATA_W-1:0]  SAT_MAX         = 16'hFFFF;
    localparam logic [DATA_W-1:0]  GAIN_LOW_RESET  = 16'h3565;
    localparam logic [DATA_W-1:0]  GAIN_HIGH_RESET = 16'h3BAB;
    localparam logic [ROUND_W-1:0] CAL_ROUNDS      = 3'd4;

    // Function codes carried in the func field; code 3 is a no-op.
    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_SAMPLE  = 2'd1,
        FUNC_MEASURE = 2'd2
    } func_t;

    // Register index, taken from paddr word bits.
    typedef enum logic [0:0] {
        REG_GAIN_LOW  = 1'b0,
        REG_GAIN_HIGH = 1'b1
    } reg_idx_t;

    // Calibration request issued when an item leaves the input stage.
    typedef struct packed {
        logic                  start;
        logic                  sample;
        logic [CH_FIELD_W-1:0] channel;
        logic [DATA_W-1:0]     raw;
    } cal_req_t;

endpackage

>>> rtl/core/aocs_in_if.sv
interface aocs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [15:0] raw_sample;

    modport source (output valid, output func, output channel, output raw_sample,
                    input ready);
    modport sink   (input valid, input func, input channel, input raw_sample,
                    output ready);
endinterface

>>> rtl/core/aocs_out_if.sv
interface aocs_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        corrected_value;
    logic signed [15:0] classic_value;
    logic               calibration_done;

    modport source (output valid, output corrected_value, output classic_value,
                    output calibration_done, input ready);
    modport sink   (input valid, input corrected_value, input classic_value,
                    input calibration_done, output ready);
endinterface

>>> rtl/core/aocs_cal.sv
`include "adc_offset_calibrate_and_scale_core_assert.svh"

module aocs_cal #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aocs_pkg::cal_req_t            req,
    input  logic [aocs_pkg::CH_FIELD_W-1:0] rd_channel,
    output logic [aocs_pkg::DATA_W-1:0]   rd_offset,
    output logic                          done_next
);
    import aocs_pkg::*;

    localparam int CH_W = $clog2(NUM_CHANNELS);

    logic [SUM_W-1:0]   sum_reg    [NUM_CHANNELS];
    logic [SUM_W-1:0]   sum_next   [NUM_CHANNELS];
    logic [DATA_W-1:0]  offset_reg [NUM_CHANNELS];
    logic [DATA_W-1:0]  offset_next[NUM_CHANNELS];
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    logic               done_reg;

    logic [CH_W-1:0]    wr_ch;
    logic               wr_in_range;
    logic [SUM_W-1:0]   sum_add;
    logic [CH_W-1:0]    rd_ch;
    logic               rd_in_range;
    logic               offset_any;

    assign wr_ch       = CH_W'(req.channel);
    assign wr_in_range = 32'(req.channel) < 32'(NUM_CHANNELS);
    assign sum_add     = sum_reg[wr_ch] + SUM_W'(req.raw);

    assign rd_ch       = CH_W'(rd_channel);
    assign rd_in_range = 32'(rd_channel) < 32'(NUM_CHANNELS);
    assign rd_offset   = rd_in_range ? offset_reg[rd_ch] : '0;

    always_comb
    begin
        sum_next    = sum_reg;
        offset_next = offset_reg;
        round_next  = round_reg;
        done_next   = done_reg;
        if (req.start)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_next[i]    = '0;
                offset_next[i] = '0;
            end
            round_next = '0;
            done_next  = 1'b0;
        end
        else if (req.sample && !done_reg && wr_in_range)
        begin
            sum_next[wr_ch] = sum_add;
            if (wr_ch == CH_W'(NUM_CHANNELS - 1))
            begin
                round_next = round_reg + ROUND_W'(1);
                if (round_next >= CAL_ROUNDS)
                begin
                    // average is sum[17:2]; subtracting mid-scale flips its top bit
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        offset_next[i] = {~sum_next[i][SUM_W-1], sum_next[i][SUM_W-2:2]};
                    end
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_reg[i]    <= '0;
                offset_reg[i] <= '0;
            end
            round_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
            round_reg  <= round_next;
            done_reg   <= done_next;
        end
    end

    always_comb
    begin
        offset_any = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            offset_any = offset_any | (|offset_reg[i]);
        end
    end

    `AOCS_ASSERT_NOW(a_done_at_full_rounds, done_reg, round_reg == CAL_ROUNDS)
    `AOCS_ASSERT_NEXT(a_start_clears, req.start, !done_reg && round_reg == '0)
    `AOCS_ASSERT_NOW(a_offsets_zero_until_done, !done_reg, !offset_any)

endmodule

>>> rtl/core/adc_offset_calibrate_and_scale_core.sv
// Channel       | Direction | Handshake         | Payload
// sample_ch     | in        | valid/ready       | func, channel, raw_sample
// result_ch     | out       | valid/ready       | corrected_value, classic_value,
//               |           |                   | calibration_done
// APB config    | in        | psel/penable      | gain_low_group @0, gain_high_group @4
//
// One transaction in, one transaction out, one per cycle sustained while result_ch is ready.
// Data passes the input register, then the result register; offset
// lookup, saturating subtract and the 16x17 gain multiply sit between them.
// rst_n clears the calibration state, the gains (to their defaults) and both
// stage valids. A stalled result holds; the input stage keeps accepting while
// the result register drains in the same cycle.
`include "adc_offset_calibrate_and_scale_core_assert.svh"

module adc_offset_calibrate_and_scale_core #(
    parameter int NUM_CHANNELS   = 8,
    parameter int LOW_GROUP_SIZE = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    aocs_in_if.sink                         sample_ch,
    aocs_out_if.source                      result_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aocs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aocs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aocs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import aocs_pkg::*;

    // ---------------- configuration registers ----------------
    logic [DATA_W-1:0] gain_low_reg;
    logic [DATA_W-1:0] gain_high_reg;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // Decode on the word address only; byte offsets alias into the word.
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_LOW:  prdata = APB_DATA_W'(gain_low_reg);
            REG_GAIN_HIGH: prdata = APB_DATA_W'(gain_high_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_low_reg  <= GAIN_LOW_RESET;
            gain_high_reg <= GAIN_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_GAIN_LOW:  gain_low_reg  <= pwdata[DATA_W-1:0];
                REG_GAIN_HIGH: gain_high_reg <= pwdata[DATA_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    logic                  s1_valid_reg;
    logic [1:0]            s1_func_reg;
    logic [CH_FIELD_W-1:0] s1_channel_reg;
    logic [DATA_W-1:0]     s1_raw_reg;
    logic                  s1_fire;
    logic                  in_fire;

    logic                  out_valid_reg;
    logic [DATA_W-1:0]     out_corrected_reg;
    logic [DATA_W-1:0]     out_classic_reg;
    logic                  out_done_reg;

    // Advance the input stage whenever the result register is empty or draining.
    assign s1_fire         = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire         = sample_ch.valid && sample_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            s1_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg    <= sample_ch.func;
            s1_channel_reg <= sample_ch.channel;
            s1_raw_reg     <= sample_ch.raw_sample;
        end
    end

    // ---------------- calibration state ----------------
    cal_req_t          cal_req;
    logic [DATA_W-1:0] offset;
    logic              done_next;

    always_comb
    begin
        cal_req.start   = s1_fire && (s1_func_reg == FUNC_START);
        cal_req.sample  = s1_fire && (s1_func_reg == FUNC_SAMPLE);
        cal_req.channel = s1_channel_reg;
        cal_req.raw     = s1_raw_reg;
    end

    aocs_cal #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_cal (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (cal_req),
        .rd_channel (s1_channel_reg),
        .rd_offset  (offset),
        .done_next  (done_next)
    );

    // ---------------- measure datapath ----------------
    // raw minus signed offset spans -32767..98303: 18 bits signed.
    logic signed [DATA_W+1:0] diff;
    logic [DATA_W-1:0]        corrected;
    logic signed [DATA_W-1:0] x_low;
    logic signed [DATA_W-1:0] x_high;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W:0]   mul_b;
    logic signed [2*DATA_W:0] product;
    logic                     is_low_group;

    assign diff = $signed({2'b00, s1_raw_reg}) - $signed({{2{offset[DATA_W-1]}}, offset});

    always_comb
    begin
        if (diff[DATA_W+1])
        begin
            corrected = '0;
        end
        else if (diff[DATA_W])
        begin
            corrected = SAT_MAX;
        end
        else
        begin
            corrected = diff[DATA_W-1:0];
        end
    end

    assign is_low_group = 32'(s1_channel_reg) < 32'(LOW_GROUP_SIZE);
    // corrected - mid-scale is corrected with its top bit flipped
    assign x_low   = $signed({~corrected[DATA_W-1], corrected[DATA_W-2:0]});
    assign x_high  = $signed(MID_SCALE - corrected);
    assign mul_a   = is_low_group ? x_low : x_high;
    assign mul_b   = $signed({1'b0, is_low_group ? gain_low_reg : gain_high_reg});
    assign product = mul_a * mul_b;

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ch.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_done_reg <= done_next;
            case (s1_func_reg)
                FUNC_MEASURE:
                begin
                    out_corrected_reg <= corrected;
                    // floor of product / 2^16, low 16 bits
                    out_classic_reg   <= product[2*DATA_W-1:DATA_W];
                end
                default:
                begin
                    out_corrected_reg <= '0;
                    out_classic_reg   <= '0;
                end
            endcase
        end
    end

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.corrected_value  = out_corrected_reg;
    assign result_ch.classic_value    = $signed(out_classic_reg);
    assign result_ch.calibration_done = out_done_reg;

    `AOCS_ASSERT_NEXT(a_stage_to_result, s1_fire, out_valid_reg)
    `AOCS_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_fire, s1_valid_reg)
    `AOCS_ASSERT_NEXT(a_non_measure_zero,
        s1_fire && s1_func_reg != FUNC_MEASURE,
        out_corrected_reg == '0 && out_classic_reg == '0)

endmodule

>>> test/tb_adc_offset_calibrate_and_scale_core.sv
module tb_adc_offset_calibrate_and_scale_core;

    import aocs_pkg::*;

    // Block configuration under test (the RTL defaults).
    localparam int NUM_CH    = 8;
    localparam int LOW_GROUP = 4;

    // Function code 3 is not in the package enum; the block treats it as a no-op.
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam int PHASE_ITEMS  = 650;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT      = 4_000_000;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  channel;
        logic [15:0] raw_sample;
    } adc_item_t;

    typedef struct packed {
        logic [15:0]        corrected;
        logic signed [15:0] classic;
        logic               done;
    } adc_result_t;

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    aocs_in_if  sample_if ();
    aocs_out_if result_if ();

    adc_offset_calibrate_and_scale_core #(
        .NUM_CHANNELS   (NUM_CH),
        .LOW_GROUP_SIZE (LOW_GROUP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_if),
        .result_ch (result_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow of the calibration state and the gain registers.
    logic [SUM_W-1:0]   sample_sums [NUM_CH];
    logic [DATA_W-1:0]  channel_offsets [NUM_CH];
    logic [ROUND_W-1:0] round_count;
    logic               cal_done;
    logic [DATA_W-1:0]  gain_low;
    logic [DATA_W-1:0]  gain_high;

    // Items waiting to be offered, and results owed by the block.
    adc_item_t   pending_items [$];
    adc_result_t expected_results [$];

    adc_item_t   next_item;
    adc_result_t want;

    int issued_count;
    int accept_count;
    int staged_count;
    int fail_count;
    int src_idle_pct;
    int snk_idle_pct;
    bit rx_hold;
    bit stall_armed;

    // Clear the calibration state, as a start transaction does.
    function automatic void clear_calibration();
        for (int i = 0; i < NUM_CH; i++)
        begin
            sample_sums[i]     = '0;
            channel_offsets[i] = '0;
        end
        round_count = '0;
        cal_done    = 1'b0;
    endfunction

    // Advance the shadow state by one accepted transaction and return the
    // result the block must produce for it.
    function automatic adc_result_t calibrate_and_correct(adc_item_t it);
        adc_result_t        res;
        logic [DATA_W-1:0]  off;
        logic [DATA_W-1:0]  corr;
        logic [DATA_W-1:0]  flipped;
        logic signed [17:0] off_s;
        logic signed [17:0] diff;
        logic signed [17:0] centered;
        logic signed [35:0] prod;
        res = '0;
        case (it.func)
            FUNC_START:
            begin
                clear_calibration();
            end
            FUNC_SAMPLE:
            begin
                // Drop samples once calibrated; only a new start reopens it.
                if (!cal_done && it.channel < NUM_CH)
                begin
                    sample_sums[it.channel] = sample_sums[it.channel]
                                            + {2'b00, it.raw_sample};
                    if (it.channel == NUM_CH - 1)
                    begin
                        round_count = round_count + 3'd1;
                        if (round_count >= CAL_ROUNDS)
                        begin
                            for (int i = 0; i < NUM_CH; i++)
                                channel_offsets[i] = sample_sums[i][SUM_W-1:2] - MID_SCALE;
                            cal_done = 1'b1;
                        end
                    end
                end
            end
            FUNC_MEASURE:
            begin
                off   = (it.channel < NUM_CH) ? channel_offsets[it.channel] : '0;
                off_s = $signed({{2{off[15]}}, off});
                diff  = $signed({2'b00, it.raw_sample}) - off_s;
                // Clamp the subtraction to the unsigned 16-bit range.
                if (diff < 0)
                    corr = '0;
                else if (diff > 18'sd65535)
                    corr = SAT_MAX;
                else
                    corr = diff[15:0];
                if (it.channel < LOW_GROUP)
                begin
                    centered = $signed({2'b00, corr}) - $signed({2'b00, MID_SCALE});
                    prod     = centered * $signed({2'b00, gain_low});
                end
                else
                begin
                    flipped  = MID_SCALE - corr;
                    centered = $signed({{2{flipped[15]}}, flipped});
                    prod     = centered * $signed({2'b00, gain_high});
                end
                res.corrected = corr;
                // Floor shift by 16 keeps bits 31:16 of the product.
                res.classic = prod[31:16];
            end
            default:
            begin
            end
        endcase
        res.done = cal_done;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock and the time limit of the run
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offer the head of the pending queue at the falling edge.
    // A new transaction is picked only once the previous one was taken,
    // which the monitor signals by advancing accept_count.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_if.valid <= 1'b0;
        end
        else if (!sample_if.valid || accept_count == issued_count)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_item = pending_items.pop_front();
                sample_if.func       <= next_item.func;
                sample_if.channel    <= next_item.channel;
                sample_if.raw_sample <= next_item.raw_sample;
                sample_if.valid      <= 1'b1;
                issued_count         <= issued_count + 1;
            end
            else
            begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: drop ready at random, or for the whole hold-off stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (rx_hold)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Hold off the receiver for a long stretch so the block backs up and
    // stalls its input while the driver keeps offering.
    initial
    begin
        rx_hold = 1'b0;
        wait (stall_armed);
        repeat (20) @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input transaction, then check each
    // accepted output transaction against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_if.valid && sample_if.ready)
            begin
                expected_results.push_back(calibrate_and_correct(
                    {sample_if.func, sample_if.channel, sample_if.raw_sample}));
                accept_count <= accept_count + 1;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none pending: corrected %h classic %h done %b",
                             $time, result_if.corrected_value, result_if.classic_value,
                             result_if.calibration_done);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_if.corrected_value !== want.corrected)
                    begin
                        $display("%0t: corrected_value expected %h actual %h",
                                 $time, want.corrected, result_if.corrected_value);
                        fail_count++;
                    end
                    if (result_if.classic_value !== want.classic)
                    begin
                        $display("%0t: classic_value expected %h actual %h",
                                 $time, want.classic, result_if.classic_value);
                        fail_count++;
                    end
                    if (result_if.calibration_done !== want.done)
                    begin
                        $display("%0t: calibration_done expected %b actual %b",
                                 $time, want.done, result_if.calibration_done);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] f, input logic [2:0] ch,
                             input logic [15:0] raw);
        adc_item_t it;
        it.func       = f;
        it.channel    = ch;
        it.raw_sample = raw;
        pending_items.push_back(it);
        staged_count++;
    endtask

    // Write one gain register over APB: setup cycle, then access cycle.
    task automatic program_gain(input reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'h0000, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_GAIN_LOW)
            gain_low = value;
        else
            gain_high = value;
    endtask

    // Hold until every offered transaction was taken and every result seen,
    // then let the pipeline settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || accept_count != issued_count ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] near_value(input int center, input int spread);
        int v;
        v = center + $urandom_range(spread) - spread / 2;
        return v[15:0];
    endfunction

    // One calibration session: a start, four rounds of samples on all
    // channels with random content, then measurements. Some sessions are
    // broken (cut short, extra samples that wrap the sums) or pure noise.
    task automatic gen_session();
        int kind;
        int base;
        int spread;
        int last_round;
        int n_meas;
        int sel;
        logic [2:0]  ch;
        logic [15:0] raw;
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            repeat ($urandom_range(4, 12))
                push_item(2'($urandom_range(3)), 3'($urandom_range(7)),
                          16'($urandom_range(65535)));
            return;
        end
        case ($urandom_range(3))
            0: spread = 0;
            1: spread = 16;
            2: spread = 2048;
            default: spread = 65535;
        endcase
        base = $urandom_range(65535);
        last_round = (kind == 1) ? $urandom_range(2) : 3;
        push_item(FUNC_START, 3'($urandom_range(7)), 16'($urandom_range(65535)));
        for (int r = 0; r <= last_round; r++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                push_item(FUNC_SAMPLE, 3'(c), near_value(base, spread));
                // Extra samples on a channel push its sum past 18 bits.
                if ($urandom_range(7) == 0)
                    push_item(FUNC_SAMPLE, 3'($urandom_range(NUM_CH - 2)),
                              near_value(base, spread));
                if ($urandom_range(29) == 0)
                    push_item(FUNC_MEASURE, 3'($urandom_range(7)),
                              16'($urandom_range(65535)));
            end
        end
        // Samples after calibration must be dropped.
        repeat ($urandom_range(2))
            push_item(FUNC_SAMPLE, 3'($urandom_range(7)), 16'($urandom_range(65535)));
        n_meas = $urandom_range(4, 20);
        repeat (n_meas)
        begin
            ch  = 3'($urandom_range(7));
            sel = $urandom_range(9);
            case (sel)
                0: raw = 16'h0000;
                1: raw = SAT_MAX;
                2: raw = MID_SCALE;
                3: raw = near_value(base, 4);
                4: raw = near_value(base - 32769, 2);
                5: raw = near_value(base + 32768, 2);
                default: raw = 16'($urandom_range(65535));
            endcase
            push_item(FUNC_MEASURE, ch, raw);
        end
        if ($urandom_range(5) == 0)
            push_item(FUNC_NOP, 3'($urandom_range(7)), 16'($urandom_range(65535)));
    endtask

    task automatic fill_random(input int target);
        staged_count = 0;
        while (staged_count < target)
            gen_session();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        sample_if.valid      = 1'b0;
        sample_if.func       = '0;
        sample_if.channel    = '0;
        sample_if.raw_sample = '0;
        result_if.ready      = 1'b0;
        issued_count         = 0;
        accept_count         = 0;
        staged_count         = 0;
        fail_count           = 0;
        stall_armed          = 1'b0;
        src_idle_pct         = 6;
        snk_idle_pct         = 75;
        clear_calibration();
        gain_low  = GAIN_LOW_RESET;
        gain_high = GAIN_HIGH_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with the reset gains.
        // Uncalibrated: offsets are zero, measure passes the raw sample.
        push_item(FUNC_START, 3'd0, 16'h0000);
        push_item(FUNC_MEASURE, 3'd0, 16'h0000);
        push_item(FUNC_MEASURE, 3'd3, 16'hFFFF);
        push_item(FUNC_MEASURE, 3'd4, 16'h8000);
        push_item(FUNC_MEASURE, 3'd7, 16'h0000);
        push_item(FUNC_NOP, 3'd5, 16'hFFFF);
        // Wrap the channel 0 sum, then finish all four rounds on channel 7
        // alone; channels 1..6 end with the most negative offset.
        push_item(FUNC_START, 3'd7, 16'hFFFF);
        repeat (5) push_item(FUNC_SAMPLE, 3'd0, 16'hFFFF);
        repeat (4) push_item(FUNC_SAMPLE, 3'd7, 16'hFFFF);
        push_item(FUNC_MEASURE, 3'd0, 16'h0000);
        // Negative offset at the exact saturation boundary.
        push_item(FUNC_MEASURE, 3'd1, 16'h7FFF);
        push_item(FUNC_MEASURE, 3'd5, 16'hFFFF);
        // Positive offset pulls a small sample below zero.
        push_item(FUNC_MEASURE, 3'd7, 16'h0000);
        // Calibrated: this sample must be dropped.
        push_item(FUNC_SAMPLE, 3'd2, 16'h1234);
        push_item(FUNC_MEASURE, 3'd2, 16'h0000);
        push_item(FUNC_NOP, 3'd2, 16'h0000);
        wait_drained();

        // Phase 1: sender mostly busy, receiver mostly idle.
        program_gain(REG_GAIN_LOW, 16'hFFFF);
        program_gain(REG_GAIN_HIGH, 16'h0000);
        fill_random(PHASE_ITEMS);
        wait_drained();

        // Phase 2: the other way round.
        src_idle_pct = 75;
        snk_idle_pct = 6;
        program_gain(REG_GAIN_LOW, 16'h0000);
        program_gain(REG_GAIN_HIGH, 16'hFFFF);
        fill_random(PHASE_ITEMS);
        wait_drained();

        // Phase 3: no idling, random gains, one long receiver hold-off.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        program_gain(REG_GAIN_LOW, 16'($urandom_range(65535)));
        program_gain(REG_GAIN_HIGH, 16'($urandom_range(65535)));
        fill_random(PHASE_ITEMS);
        stall_armed = 1'b1;
        wait_drained();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
